// ===== rtl/ahdsr_envelope_gain_top_assert.svh =====
// Assertion macros for the AHDSR envelope gain block.
// Used by ahdsr_envelope_gain_top.sv; expects clk and arst_n in scope.
`ifndef AHDSR_ENVELOPE_GAIN_TOP_ASSERT_SVH
`define AHDSR_ENVELOPE_GAIN_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AEG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aeg_pkg.sv =====
// Shared types and constants for the AHDSR envelope gain block.
// No dependencies; used by every RTL module of the block.
package aeg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int LEN_W      = 24;
	localparam int PHASE_W    = 3;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = 3;
	localparam int QUOT_W     = 16;
	localparam int PROD_W     = GAIN_W + LEN_W;
	localparam int SPROD_W    = SAMPLE_W + GAIN_W + 1;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd4;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_START_GAIN    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_LEN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_LEN     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FADE_ENABLE   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FADE_LEN      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd7;

	typedef struct packed {
		logic [GAIN_W-1:0] start_gain;
		logic [LEN_W-1:0]  attack_len;
		logic [LEN_W-1:0]  hold_len;
		logic [LEN_W-1:0]  decay_len;
		logic [GAIN_W-1:0] sustain_level;
		logic              fade_enable;
		logic [LEN_W-1:0]  fade_len;
		logic [LEN_W-1:0]  release_len;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic div_start;
		logic gain;
		logic scale;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

// ===== rtl/aeg_regs.sv =====
// Configuration register bank with an APB-style write and read port.
// Depends on aeg_pkg for the register layout and index codes.
module aeg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aeg_pkg::ADDR_W-1:0]  paddr,
	input  logic [aeg_pkg::DATA_W-1:0]  pwdata,
	output logic [aeg_pkg::DATA_W-1:0]  prdata,
	output aeg_pkg::cfg_t               cfg
);

	aeg_pkg::cfg_t                    cfg_q;
	logic [aeg_pkg::REG_IDX_W-1:0]    idx;
	logic                             wr_en;

	assign idx   = paddr[aeg_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_gain    <= '0;
			cfg_q.attack_len    <= '0;
			cfg_q.hold_len      <= '0;
			cfg_q.decay_len     <= '0;
			cfg_q.sustain_level <= aeg_pkg::GAIN_ONE;
			cfg_q.fade_enable   <= 1'b0;
			cfg_q.fade_len      <= '0;
			cfg_q.release_len   <= '0;
		end else if (wr_en) begin
			case (idx)
				aeg_pkg::REG_START_GAIN:    cfg_q.start_gain    <= pwdata[aeg_pkg::GAIN_W-1:0];
				aeg_pkg::REG_ATTACK_LEN:    cfg_q.attack_len    <= pwdata[aeg_pkg::LEN_W-1:0];
				aeg_pkg::REG_HOLD_LEN:      cfg_q.hold_len      <= pwdata[aeg_pkg::LEN_W-1:0];
				aeg_pkg::REG_DECAY_LEN:     cfg_q.decay_len     <= pwdata[aeg_pkg::LEN_W-1:0];
				aeg_pkg::REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= pwdata[aeg_pkg::GAIN_W-1:0];
				aeg_pkg::REG_FADE_ENABLE:   cfg_q.fade_enable   <= pwdata[0];
				aeg_pkg::REG_FADE_LEN:      cfg_q.fade_len      <= pwdata[aeg_pkg::LEN_W-1:0];
				aeg_pkg::REG_RELEASE_LEN:   cfg_q.release_len   <= pwdata[aeg_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			aeg_pkg::REG_START_GAIN:    prdata = aeg_pkg::DATA_W'(cfg_q.start_gain);
			aeg_pkg::REG_ATTACK_LEN:    prdata = aeg_pkg::DATA_W'(cfg_q.attack_len);
			aeg_pkg::REG_HOLD_LEN:      prdata = aeg_pkg::DATA_W'(cfg_q.hold_len);
			aeg_pkg::REG_DECAY_LEN:     prdata = aeg_pkg::DATA_W'(cfg_q.decay_len);
			aeg_pkg::REG_SUSTAIN_LEVEL: prdata = aeg_pkg::DATA_W'(cfg_q.sustain_level);
			aeg_pkg::REG_FADE_ENABLE:   prdata = aeg_pkg::DATA_W'(cfg_q.fade_enable);
			aeg_pkg::REG_FADE_LEN:      prdata = aeg_pkg::DATA_W'(cfg_q.fade_len);
			aeg_pkg::REG_RELEASE_LEN:   prdata = aeg_pkg::DATA_W'(cfg_q.release_len);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/aeg_ctrl.sv =====
// Sequencing state machine for the AHDSR envelope gain block.
// Depends on aeg_pkg for the command and status structs.
module aeg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output aeg_pkg::cmd_t cmd,
	input  aeg_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DLOAD = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_GAIN  = 3'd5;
	localparam logic [2:0] S_SCALE = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_GAIN;
				end
			end
			S_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/aeg_dp.sv =====
// Datapath: envelope phase walk, ramp multiply, serial divider and sample scaling.
// Depends on aeg_pkg for widths, phase codes and the command and status structs.
module aeg_dp #(
	parameter int TIME_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aeg_pkg::cmd_t                       cmd,
	output aeg_pkg::sts_t                       sts,
	input  aeg_pkg::cfg_t                       cfg,
	input  logic signed [aeg_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                gate,
	output logic signed [aeg_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                active,
	output logic [aeg_pkg::PHASE_W-1:0]         phase_now
);

	localparam int CMP_W = (TIME_BITS > aeg_pkg::LEN_W) ? TIME_BITS : aeg_pkg::LEN_W;
	localparam int CNT_W = $clog2(aeg_pkg::QUOT_W);
	localparam int LOW_W = aeg_pkg::PROD_W - aeg_pkg::LEN_W;

	// Captured item and envelope state.
	logic signed [aeg_pkg::SAMPLE_W-1:0] sample_q;
	logic                                gate_q;
	logic [aeg_pkg::PHASE_W-1:0]         phase_q;
	logic [TIME_BITS-1:0]                elapsed_q;
	logic [aeg_pkg::GAIN_W-1:0]          held_q;

	// Ramp operands.
	logic [aeg_pkg::GAIN_W-1:0] from_q;
	logic [aeg_pkg::GAIN_W-1:0] mag_q;
	logic                       neg_q;
	logic [aeg_pkg::LEN_W-1:0]  rt_q;
	logic [aeg_pkg::LEN_W-1:0]  len_q;
	logic                       upd_q;

	logic [aeg_pkg::PROD_W-1:0] prod_q;

	// Restoring divider.
	logic [aeg_pkg::LEN_W-1:0]  rem_q;
	logic [LOW_W-1:0]           low_q;
	logic [aeg_pkg::QUOT_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [aeg_pkg::LEN_W:0]    trial;
	logic [aeg_pkg::LEN_W:0]    trial_sub;
	logic                       q_bit;

	logic [aeg_pkg::GAIN_W-1:0]         gain_q;
	logic signed [aeg_pkg::SPROD_W-1:0] sprod_q;
	logic signed [aeg_pkg::SPROD_W-1:0] sbias;
	logic [aeg_pkg::GAIN_W-1:0]         gain_d;

	logic signed [aeg_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                active_q;
	logic [aeg_pkg::PHASE_W-1:0]         phase_now_q;

	// Phase walk results.
	logic [aeg_pkg::PHASE_W-1:0] ph;
	logic [CMP_W-1:0]            t;
	logic                        hit;
	logic [aeg_pkg::GAIN_W-1:0]  nx_from;
	logic [aeg_pkg::GAIN_W-1:0]  nx_mag;
	logic                        nx_neg;
	logic [aeg_pkg::LEN_W-1:0]   nx_rt;
	logic [aeg_pkg::LEN_W-1:0]   nx_len;
	logic                        nx_upd;
	logic [aeg_pkg::GAIN_W-1:0]  sg;
	logic [aeg_pkg::GAIN_W-1:0]  sus;
	logic [TIME_BITS-1:0]        t_tb;
	logic [TIME_BITS-1:0]        elapsed_d;

	assign sg  = (cfg.start_gain > aeg_pkg::GAIN_ONE) ? aeg_pkg::GAIN_ONE : cfg.start_gain;
	assign sus = (cfg.sustain_level > aeg_pkg::GAIN_ONE) ? aeg_pkg::GAIN_ONE
		: cfg.sustain_level;

	// Walks through every phase that has already run out within this tick.
	always_comb begin
		ph      = phase_q;
		t       = CMP_W'(elapsed_q);
		hit     = 1'b0;
		nx_from = '0;
		nx_mag  = '0;
		nx_neg  = 1'b0;
		nx_rt   = '0;
		nx_len  = aeg_pkg::LEN_W'(1);
		nx_upd  = 1'b0;
		if (ph > aeg_pkg::PH_RELEASE) begin
			ph = aeg_pkg::PH_IDLE;
		end
		if (ph != aeg_pkg::PH_IDLE && ph != aeg_pkg::PH_RELEASE && !gate_q) begin
			ph = aeg_pkg::PH_RELEASE;
			t  = '0;
		end
		if (ph == aeg_pkg::PH_ATTACK) begin
			if (t < CMP_W'(cfg.attack_len)) begin
				hit     = 1'b1;
				nx_upd  = 1'b1;
				nx_from = sg;
				nx_mag  = aeg_pkg::GAIN_ONE - sg;
				nx_rt   = t[aeg_pkg::LEN_W-1:0];
				nx_len  = cfg.attack_len;
			end else begin
				ph = aeg_pkg::PH_HOLD;
				t  = '0;
			end
		end
		if (!hit && ph == aeg_pkg::PH_HOLD) begin
			if (t < CMP_W'(cfg.hold_len)) begin
				hit     = 1'b1;
				nx_upd  = 1'b1;
				nx_from = aeg_pkg::GAIN_ONE;
			end else begin
				ph = aeg_pkg::PH_DECAY;
				t  = '0;
			end
		end
		if (!hit && ph == aeg_pkg::PH_DECAY) begin
			if (t < CMP_W'(cfg.decay_len)) begin
				hit     = 1'b1;
				nx_upd  = 1'b1;
				nx_from = aeg_pkg::GAIN_ONE;
				nx_mag  = aeg_pkg::GAIN_ONE - sus;
				nx_neg  = 1'b1;
				nx_rt   = t[aeg_pkg::LEN_W-1:0];
				nx_len  = cfg.decay_len;
			end else begin
				ph = aeg_pkg::PH_SUSTAIN;
				t  = '0;
			end
		end
		if (!hit && ph == aeg_pkg::PH_SUSTAIN) begin
			hit    = 1'b1;
			nx_upd = 1'b1;
			if (!cfg.fade_enable) begin
				nx_from = sus;
			end else if (t < CMP_W'(cfg.fade_len)) begin
				nx_from = sus;
				nx_mag  = sus;
				nx_neg  = 1'b1;
				nx_rt   = t[aeg_pkg::LEN_W-1:0];
				nx_len  = cfg.fade_len;
			end
		end
		if (!hit && ph == aeg_pkg::PH_RELEASE) begin
			if (cfg.release_len == '0 || t > CMP_W'(cfg.release_len)) begin
				ph = aeg_pkg::PH_IDLE;
			end else if (t != CMP_W'(cfg.release_len)) begin
				nx_from = held_q;
				nx_mag  = held_q;
				nx_neg  = 1'b1;
				nx_rt   = t[aeg_pkg::LEN_W-1:0];
				nx_len  = cfg.release_len;
			end
		end
	end

	assign t_tb      = t[TIME_BITS-1:0];
	assign elapsed_d = (&t_tb) ? t_tb : t_tb + 1'b1;

	// One divider step: shift in the next dividend bit and try the subtraction.
	assign trial     = {rem_q, low_q[LOW_W-1]};
	assign trial_sub = trial - {1'b0, len_q};
	assign q_bit     = (trial >= {1'b0, len_q});

	assign gain_d = neg_q ? (from_q - quo_q) : (from_q + quo_q);

	// Truncation toward zero of the product divided by one in Q1.15.
	assign sbias = sprod_q + (sprod_q[aeg_pkg::SPROD_W-1]
		? aeg_pkg::SPROD_W'(32767) : aeg_pkg::SPROD_W'(0));

	assign sts.div_done = busy_q && (cnt_q == CNT_W'(aeg_pkg::QUOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= aeg_pkg::PH_ATTACK;
			elapsed_q <= '0;
			held_q    <= '0;
			busy_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cmd.eval) begin
				phase_q   <= ph;
				elapsed_q <= elapsed_d;
			end
			if (cmd.gain && upd_q) begin
				held_q <= gain_d;
			end
			if (cmd.div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(aeg_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			gate_q   <= gate;
		end
		if (cmd.eval) begin
			from_q <= nx_from;
			mag_q  <= nx_mag;
			neg_q  <= nx_neg;
			rt_q   <= nx_rt;
			len_q  <= nx_len;
			upd_q  <= nx_upd;
		end
		if (cmd.mul) begin
			prod_q <= mag_q * rt_q;
		end
		if (cmd.div_start) begin
			rem_q <= prod_q[aeg_pkg::PROD_W-1:LOW_W];
			low_q <= prod_q[LOW_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? trial_sub[aeg_pkg::LEN_W-1:0] : trial[aeg_pkg::LEN_W-1:0];
			low_q <= {low_q[LOW_W-2:0], 1'b0};
			quo_q <= {quo_q[aeg_pkg::QUOT_W-2:0], q_bit};
		end
		if (cmd.gain) begin
			gain_q <= gain_d;
		end
		if (cmd.scale) begin
			sprod_q <= sample_q * $signed({1'b0, gain_q});
		end
		if (cmd.out_load) begin
			out_sample_q <= sbias[aeg_pkg::SAMPLE_W+14:15];
			active_q     <= (phase_q != aeg_pkg::PH_IDLE);
			phase_now_q  <= phase_q;
		end
	end

	assign out_sample = out_sample_q;
	assign active     = active_q;
	assign phase_now  = phase_now_q;

endmodule

// ===== rtl/ahdsr_envelope_gain_top.sv =====
// AHDSR envelope gain, top level. Each item is one audio tick: a signed 16-bit
// sample and a gate bit come in, and the sample scaled by a Q1.15 envelope comes
// out together with the envelope phase after that tick. The envelope runs
// attack, hold, decay, sustain (optionally fading linearly to zero) and release;
// phases whose length has run out are passed within the same tick, and a low
// gate sends any held phase straight to release. After release the block reports
// idle and outputs zero until reset. Items are taken one at a time, and each
// passes in order through the phase walk, the ramp multiply, the divider load,
// the restoring divider that forms each ramp value, the gain step, the sample
// multiply and the load of the output register. The next item is accepted in
// the cycle after the result is loaded, even while that result still waits
// for out_ready. Configuration lives on an APB-style port at byte addresses
// 0x00 to 0x1C and must be written only while the block is idle. Depends on
// aeg_pkg, aeg_regs, aeg_ctrl and aeg_dp.
`include "ahdsr_envelope_gain_top_assert.svh"

module ahdsr_envelope_gain_top #(
	parameter int TIME_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [aeg_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                gate,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [aeg_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                active,
	output logic [aeg_pkg::PHASE_W-1:0]         phase_now,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [aeg_pkg::ADDR_W-1:0]          paddr,
	input  logic [aeg_pkg::DATA_W-1:0]          pwdata,
	output logic [aeg_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	aeg_pkg::cfg_t cfg;
	aeg_pkg::cmd_t cmd;
	aeg_pkg::sts_t sts;

	// The register port never stalls.
	assign pready = 1'b1;

	aeg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The controller sequences each item through the datapath and owns both
	// handshakes; the datapath holds the envelope state and the output payload.
	aeg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	aeg_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg        (cfg),
		.in_sample  (in_sample),
		.gate       (gate),
		.out_sample (out_sample),
		.active     (active),
		.phase_now  (phase_now)
	);

	// The active flag must agree with the reported phase.
	`AEG_ASSERT_SAME(a_active_matches_phase, out_valid, active == (phase_now != aeg_pkg::PH_IDLE), "active flag disagrees with phase")
	// An idle envelope must give silence.
	`AEG_ASSERT_SAME(a_idle_is_silent, out_valid && !active, out_sample == '0, "nonzero sample while idle")
	// Items are processed one at a time, so acceptance closes the input.
	`AEG_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "input reopened while item in flight")

endmodule

// ===== verif/tb_ahdsr_envelope_gain_top.sv =====
// Self-checking testbench for ahdsr_envelope_gain_top: a directed table, then
// random ticks that walk one envelope from attack to idle, checked against a predictor.
// Depends on aeg_pkg and the RTL of the block; needs nothing else.
module tb_ahdsr_envelope_gain_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Result of one tick, laid out like the output ports.
	typedef struct packed {
		logic signed [aeg_pkg::SAMPLE_W-1:0] sample;
		logic                                active;
		logic [aeg_pkg::PHASE_W-1:0]         phase;
	} env_result_t;

	// One row of the directed table: either a register write or one tick.
	// Rows with a typed result carry the value that is obvious by inspection.
	typedef struct {
		bit                                  is_cfg;
		logic [aeg_pkg::REG_IDX_W-1:0]       idx;
		logic [aeg_pkg::DATA_W-1:0]          value;
		logic signed [aeg_pkg::SAMPLE_W-1:0] sample;
		logic                                gate;
		bit                                  typed;
		env_result_t                         want;
	} stim_row_t;

	localparam int     TICK_BITS      = 24;
	localparam longint TICK_MAX       = (longint'(1) << TICK_BITS) - 1;
	localparam int     SETTLE_CYCLES  = 30;     // margin for the block to settle after draining
	localparam int     HOLDOFF_CYCLES = 400;
	localparam int     CYCLE_LIMIT    = 400000;
	localparam logic [aeg_pkg::LEN_W-1:0] LEN_MAX = '1;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic signed [aeg_pkg::SAMPLE_W-1:0] in_sample = '0;
	logic                                gate      = 1'b1;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [aeg_pkg::SAMPLE_W-1:0] out_sample;
	logic                                active;
	logic [aeg_pkg::PHASE_W-1:0]         phase_now;
	logic                                psel      = 1'b0;
	logic                                penable   = 1'b0;
	logic                                pwrite    = 1'b0;
	logic [aeg_pkg::ADDR_W-1:0]          paddr     = '0;
	logic [aeg_pkg::DATA_W-1:0]          pwdata    = '0;
	logic [aeg_pkg::DATA_W-1:0]          prdata;
	logic                                pready;

	ahdsr_envelope_gain_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.gate      (gate),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sample(out_sample),
		.active    (active),
		.phase_now (phase_now),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// Predictor state: its own copy of the registers and of the envelope.
	aeg_pkg::cfg_t               env_cfg;
	logic [aeg_pkg::PHASE_W-1:0] env_phase;
	longint                      env_ticks;
	logic [aeg_pkg::GAIN_W-1:0]  env_held;

	// Results still owed by the block, oldest first.
	env_result_t pending_results[$];
	stim_row_t   directed_rows[$];

	int          mismatches   = 0;
	int          results_seen = 0;
	int          tx_gap_pct   = 0;
	int          rx_stall_pct = 0;
	int          holdoff_seq  = 0;
	int          holdoff_seen = 0;
	int          holdoff_left = 0;
	int unsigned cycle_count  = 0;

	function automatic longint clamp_gain(logic [aeg_pkg::GAIN_W-1:0] g);
		return (g > aeg_pkg::GAIN_ONE) ? longint'(aeg_pkg::GAIN_ONE) : longint'(g);
	endfunction

	// Linear interpolation with the division truncated toward zero.
	function automatic longint ramp_level(longint from_lvl, longint to_lvl, longint t,
			longint len);
		return from_lvl + ((to_lvl - from_lvl) * t) / len;
	endfunction

	function automatic logic [aeg_pkg::SAMPLE_W-1:0] scaled_sample(
			logic signed [aeg_pkg::SAMPLE_W-1:0] s, longint gain);
		longint p;
		p = (longint'(s) * gain) / longint'(aeg_pkg::GAIN_ONE);
		return p[aeg_pkg::SAMPLE_W-1:0];
	endfunction

	// Advances the envelope by one tick and returns what the block should output.
	// Phases that have run out hand over to the next one within the same tick.
	function automatic env_result_t envelope_tick(logic signed [aeg_pkg::SAMPLE_W-1:0] s,
			logic g);
		longint                       sg;
		longint                       sus;
		longint                       t;
		logic [aeg_pkg::SAMPLE_W-1:0] res;
		bit                           done;
		env_result_t                  r;
		sg   = clamp_gain(env_cfg.start_gain);
		sus  = clamp_gain(env_cfg.sustain_level);
		res  = '0;
		done = 1'b0;
		if (env_phase > aeg_pkg::PH_RELEASE)
			env_phase = aeg_pkg::PH_IDLE;
		// A dropped gate cuts any held phase short and restarts the clock.
		if (env_phase != aeg_pkg::PH_IDLE && env_phase != aeg_pkg::PH_RELEASE && !g) begin
			env_phase = aeg_pkg::PH_RELEASE;
			env_ticks = 0;
		end
		t = env_ticks;
		if (env_phase == aeg_pkg::PH_ATTACK) begin
			if (t < longint'(env_cfg.attack_len)) begin
				env_held = aeg_pkg::GAIN_W'(ramp_level(sg, longint'(aeg_pkg::GAIN_ONE), t,
					longint'(env_cfg.attack_len)));
				res  = scaled_sample(s, longint'(env_held));
				done = 1'b1;
			end else begin
				env_phase = aeg_pkg::PH_HOLD;
				t = 0;
			end
		end
		if (!done && env_phase == aeg_pkg::PH_HOLD) begin
			if (t < longint'(env_cfg.hold_len)) begin
				env_held = aeg_pkg::GAIN_ONE;
				res  = scaled_sample(s, longint'(env_held));
				done = 1'b1;
			end else begin
				env_phase = aeg_pkg::PH_DECAY;
				t = 0;
			end
		end
		if (!done && env_phase == aeg_pkg::PH_DECAY) begin
			if (t < longint'(env_cfg.decay_len)) begin
				env_held = aeg_pkg::GAIN_W'(ramp_level(longint'(aeg_pkg::GAIN_ONE), sus, t,
					longint'(env_cfg.decay_len)));
				res  = scaled_sample(s, longint'(env_held));
				done = 1'b1;
			end else begin
				env_phase = aeg_pkg::PH_SUSTAIN;
				t = 0;
			end
		end
		if (!done && env_phase == aeg_pkg::PH_SUSTAIN) begin
			if (env_cfg.fade_enable) begin
				if (t < longint'(env_cfg.fade_len))
					env_held = aeg_pkg::GAIN_W'(ramp_level(sus, 0, t,
						longint'(env_cfg.fade_len)));
				else
					env_held = '0;
			end else begin
				env_held = aeg_pkg::GAIN_W'(sus);
			end
			res  = scaled_sample(s, longint'(env_held));
			done = 1'b1;
		end
		if (!done && env_phase == aeg_pkg::PH_RELEASE) begin
			if (env_cfg.release_len == '0 || t > longint'(env_cfg.release_len)) begin
				env_phase = aeg_pkg::PH_IDLE;
				res = '0;
			end else if (t == longint'(env_cfg.release_len)) begin
				res = '0;
			end else begin
				res = scaled_sample(s, ramp_level(longint'(env_held), 0, t,
					longint'(env_cfg.release_len)));
			end
		end
		env_ticks = (t < TICK_MAX) ? t + 1 : TICK_MAX;
		r.sample = res;
		r.active = (env_phase != aeg_pkg::PH_IDLE);
		r.phase  = env_phase;
		return r;
	endfunction

	function automatic void add_cfg(logic [aeg_pkg::REG_IDX_W-1:0] idx,
			logic [aeg_pkg::DATA_W-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.value  = value;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_item(logic signed [aeg_pkg::SAMPLE_W-1:0] s, logic g);
		stim_row_t row;
		row = '{default: '0};
		row.sample = s;
		row.gate   = g;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_checked(logic signed [aeg_pkg::SAMPLE_W-1:0] s, logic g,
			logic signed [aeg_pkg::SAMPLE_W-1:0] want_sample,
			logic [aeg_pkg::PHASE_W-1:0] want_phase);
		stim_row_t row;
		row = '{default: '0};
		row.sample       = s;
		row.gate         = g;
		row.typed        = 1'b1;
		row.want.sample  = want_sample;
		row.want.active  = (want_phase != aeg_pkg::PH_IDLE);
		row.want.phase   = want_phase;
		directed_rows.push_back(row);
	endfunction

	// Biased toward the extremes of the sample range.
	function automatic logic signed [aeg_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			default: return aeg_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		mismatches++;
		$display("mismatch on %s in result %0d: got %0d, want %0d", field, results_seen, got,
			want);
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_gap_pct = tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	// Offers one item, waits for it to be taken, and records what it must produce.
	// Valid stays high across back-to-back items; it only drops for a gap or a drain.
	task automatic send_item(input logic signed [aeg_pkg::SAMPLE_W-1:0] s, input logic g,
			input bit typed, input env_result_t typed_want);
		env_result_t predicted;
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= s;
		gate      <= g;
		do @(posedge clk); while (!in_ready);
		predicted = envelope_tick(s, g);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic run_items(input int n, input bit random_gate);
		for (int i = 0; i < n; i++)
			send_item(pick_sample(), random_gate ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0,
				'0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only once the block has nothing in flight.
	task automatic write_reg(input logic [aeg_pkg::REG_IDX_W-1:0] idx,
			input logic [aeg_pkg::DATA_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			aeg_pkg::REG_START_GAIN:
				env_cfg.start_gain    = value[aeg_pkg::GAIN_W-1:0];
			aeg_pkg::REG_ATTACK_LEN:
				env_cfg.attack_len    = value[aeg_pkg::LEN_W-1:0];
			aeg_pkg::REG_HOLD_LEN:
				env_cfg.hold_len      = value[aeg_pkg::LEN_W-1:0];
			aeg_pkg::REG_DECAY_LEN:
				env_cfg.decay_len     = value[aeg_pkg::LEN_W-1:0];
			aeg_pkg::REG_SUSTAIN_LEVEL:
				env_cfg.sustain_level = value[aeg_pkg::GAIN_W-1:0];
			aeg_pkg::REG_FADE_ENABLE:
				env_cfg.fade_enable   = value[0];
			aeg_pkg::REG_FADE_LEN:
				env_cfg.fade_len      = value[aeg_pkg::LEN_W-1:0];
			aeg_pkg::REG_RELEASE_LEN:
				env_cfg.release_len   = value[aeg_pkg::LEN_W-1:0];
			default: ;
		endcase
	endtask

	// Receiver: checks every accepted result against the oldest expectation and
	// drives out_ready. A change of holdoff_seq starts a long stretch with
	// out_ready low, counted here, so the block backs up onto its input.
	always @(posedge clk) begin : result_side
		env_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", out_sample, 0);
				end else begin
					want = pending_results.pop_front();
					if (out_sample !== want.sample)
						report_mismatch("out_sample", out_sample, want.sample);
					if (active !== want.active)
						report_mismatch("active", active, want.active);
					if (phase_now !== want.phase)
						report_mismatch("phase_now", phase_now, want.phase);
				end
				results_seen++;
			end
			if (holdoff_seen != holdoff_seq) begin
				holdoff_seen <= holdoff_seq;
				holdoff_left <= HOLDOFF_CYCLES;
				out_ready    <= 1'b0;
			end else if (holdoff_left != 0) begin
				holdoff_left <= holdoff_left - 1;
				out_ready    <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[ahdsr_envelope_gain_top] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int n;

		// Predictor starts from the reset state of the block.
		env_cfg               = '0;
		env_cfg.sustain_level = aeg_pkg::GAIN_ONE;
		env_phase             = aeg_pkg::PH_ATTACK;
		env_ticks             = 0;
		env_held              = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, all in attack. With the start level at zero and the
		// longest ramp the gain is still zero on the first ticks.
		add_cfg(aeg_pkg::REG_START_GAIN, 32'd0);
		add_cfg(aeg_pkg::REG_ATTACK_LEN, 32'(LEN_MAX));
		add_checked(16'sh7FFF, 1'b1, 16'sh0000, aeg_pkg::PH_ATTACK);
		add_checked(16'sh8000, 1'b1, 16'sh0000, aeg_pkg::PH_ATTACK);
		// A start level above one saturates, so the sample passes unchanged.
		add_cfg(aeg_pkg::REG_START_GAIN, 32'h0000_FFFF);
		add_checked(16'sh7FFF, 1'b1, 16'sh7FFF, aeg_pkg::PH_ATTACK);
		add_checked(16'sh8000, 1'b1, 16'sh8000, aeg_pkg::PH_ATTACK);
		add_checked(16'sh0000, 1'b1, 16'sh0000, aeg_pkg::PH_ATTACK);
		add_checked(-16'sd1, 1'b1, -16'sd1, aeg_pkg::PH_ATTACK);
		add_cfg(aeg_pkg::REG_START_GAIN, 32'h0000_8001);
		add_checked(16'sd1, 1'b1, 16'sd1, aeg_pkg::PH_ATTACK);
		// Half gain: odd and negative samples show truncation toward zero.
		add_cfg(aeg_pkg::REG_START_GAIN, 32'd16384);
		add_item(16'sd12345, 1'b1);
		add_item(-16'sd12345, 1'b1);
		add_item(-16'sd1, 1'b1);
		add_item(16'sh5555, 1'b1);
		add_item(16'shAAAA, 1'b1);

		set_idling(0, 0);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			else
				send_item(directed_rows[i].sample, directed_rows[i].gate,
					directed_rows[i].typed, directed_rows[i].want);
		end

		// Attack ramp with random start levels; it ends exactly at its length.
		write_reg(aeg_pkg::REG_START_GAIN, $urandom_range(0, 65535));
		n = $urandom_range(250, 320);
		write_reg(aeg_pkg::REG_ATTACK_LEN, 32'(env_ticks + n));
		run_items(n / 2, 1'b0);
		write_reg(aeg_pkg::REG_START_GAIN, $urandom_range(0, 32768));
		run_items(n - n / 2, 1'b0);

		// Hold at full level while the sender is mostly idle. Halfway the sender
		// waits until the block has delivered everything.
		set_idling(62, 0);
		write_reg(aeg_pkg::REG_HOLD_LEN, 32'd120);
		run_items(60, 1'b0);
		drain_results();
		run_items(60, 1'b0);

		// Decay toward a random sustain level under receiver stalls, then toward
		// zero with both sides idling. A zero hold length is passed at once.
		set_idling(0, 62);
		write_reg(aeg_pkg::REG_HOLD_LEN, 32'd0);
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, $urandom_range(0, 32768));
		write_reg(aeg_pkg::REG_DECAY_LEN, 32'd400);
		run_items(200, 1'b0);
		set_idling(15, 15);
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, 32'd0);
		run_items(200, 1'b0);

		// Sustain with a saturated level; the receiver goes deaf for a long
		// stretch while items keep coming, so the input backs up.
		set_idling(0, 0);
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, 32'h0000_FFFF);
		holdoff_seq <= holdoff_seq + 1;
		run_items(100, 1'b0);

		// Linear fade runs out partway, gain stays zero until the fade length is maxed.
		set_idling(62, 0);
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, $urandom_range(1, 32768));
		write_reg(aeg_pkg::REG_FADE_ENABLE, 32'd1);
		write_reg(aeg_pkg::REG_FADE_LEN, 32'(env_ticks + 150));
		run_items(250, 1'b0);
		set_idling(0, 62);
		write_reg(aeg_pkg::REG_FADE_LEN, 32'd0);
		run_items(20, 1'b0);
		write_reg(aeg_pkg::REG_FADE_LEN, 32'(LEN_MAX));
		run_items(30, 1'b0);

		// Plain sustain again so release starts from a nonzero level.
		set_idling(15, 15);
		write_reg(aeg_pkg::REG_FADE_ENABLE, 32'd0);
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, $urandom_range(8192, 32768));
		run_items(50, 1'b0);

		// Release: the gate drops once, after that it is ignored. The length is
		// changed on the way, the last ramp tick lands on its end exactly, and a
		// zero length then sends the block idle for good.
		set_idling(0, 0);
		write_reg(aeg_pkg::REG_RELEASE_LEN, 32'd200);
		send_item(pick_sample(), 1'b0, 1'b0, '0);
		run_items(99, 1'b1);
		set_idling(0, 62);
		write_reg(aeg_pkg::REG_RELEASE_LEN, 32'(LEN_MAX));
		run_items(60, 1'b1);
		set_idling(62, 0);
		write_reg(aeg_pkg::REG_RELEASE_LEN, 32'd220);
		run_items(61, 1'b1);
		set_idling(15, 15);
		write_reg(aeg_pkg::REG_RELEASE_LEN, 32'd0);
		run_items(100, 1'b1);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);
		if (mismatches == 0) begin
			$display("[ahdsr_envelope_gain_top] OK");
		end else begin
			$display("[ahdsr_envelope_gain_top] ERROR");
		end
		$finish;
	end

endmodule
